[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// Clocked check that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/yuvrgb_pkg.sv]
`default_nettype none
package yuvrgb_pkg;

	// Output byte order of each pixel.
	typedef enum logic {
		ORDER_RGB = 1'b0,
		ORDER_BGR = 1'b1
	} chan_order_t;

	// Chroma contributions shared by both pixels of a macropixel.
	typedef struct packed {
		logic signed [9:0] off0;
		logic signed [9:0] off1;
		logic signed [9:0] off2;
	} chroma_off_t;

	localparam logic [7:0] CHROMA_BIAS = 8'd128;

	localparam logic signed [16:0] COEF_A_CH0 = 17'sd104;
	localparam logic signed [16:0] COEF_B_CH1 = 17'sd89;
	localparam logic signed [16:0] COEF_A_CH1 = 17'sd183;
	localparam logic signed [16:0] COEF_B_CH2 = 17'sd199;

endpackage
`default_nettype wire

[rtl/core/yuvrgb_chroma.sv]
`default_nettype none
module yuvrgb_chroma
	import yuvrgb_pkg::*;
(
	input  wire logic [7:0] chroma_a,
	input  wire logic [7:0] chroma_b,
	output chroma_off_t     off
);

	logic signed [7:0]  ca;
	logic signed [7:0]  cb;
	logic signed [16:0] p_a0;
	logic signed [16:0] p_b1;
	logic signed [16:0] p_a1;
	logic signed [16:0] p_b2;
	logic signed [8:0]  t_a0;
	logic signed [8:0]  t_b1;
	logic signed [8:0]  t_a1;
	logic signed [8:0]  t_b2;

	// Removing the bias modulo 256 leaves the centered chroma in two's complement.
	assign ca = chroma_a - CHROMA_BIAS;
	assign cb = chroma_b - CHROMA_BIAS;

	assign p_a0 = 17'(ca) * COEF_A_CH0;
	assign p_b1 = 17'(cb) * COEF_B_CH1;
	assign p_a1 = 17'(ca) * COEF_A_CH1;
	assign p_b2 = 17'(cb) * COEF_B_CH2;

	// Dropping the low byte of a two's complement product is a floor shift.
	assign t_a0 = p_a0[16:8];
	assign t_b1 = p_b1[16:8];
	assign t_a1 = p_a1[16:8];
	assign t_b2 = p_b2[16:8];

	assign off.off0 = 10'(ca) + 10'(t_a0);
	assign off.off1 = 10'sd0 - (10'(t_b1) + 10'(t_a1));
	assign off.off2 = 10'(cb) + 10'(t_b2);

endmodule
`default_nettype wire

[rtl/core/yuvrgb_pixel.sv]
`default_nettype none
module yuvrgb_pixel
	import yuvrgb_pkg::*;
(
	input  wire logic [7:0]  luma,
	input  wire chroma_off_t off,
	input  wire chan_order_t order,
	output logic [7:0]       byte0,
	output logic [7:0]       byte1,
	output logic [7:0]       byte2
);

	logic signed [10:0] sum0;
	logic signed [10:0] sum1;
	logic signed [10:0] sum2;
	logic [7:0]         ch0;
	logic [7:0]         ch1;
	logic [7:0]         ch2;

	function automatic logic [7:0] sat8(input logic signed [10:0] x);
		logic [7:0] r;
		if (x[10]) begin
			r = 8'd0;
		end else if (x[9:8] != 2'b00) begin
			r = 8'd255;
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

	assign sum0 = $signed({3'b000, luma}) + 11'(off.off0);
	assign sum1 = $signed({3'b000, luma}) + 11'(off.off1);
	assign sum2 = $signed({3'b000, luma}) + 11'(off.off2);

	assign ch0 = sat8(sum0);
	assign ch1 = sat8(sum1);
	assign ch2 = sat8(sum2);

	always_comb begin
		unique case (order)
			ORDER_BGR: begin
				byte0 = ch2;
				byte1 = ch1;
				byte2 = ch0;
			end
			default: begin
				byte0 = ch0;
				byte1 = ch1;
				byte2 = ch2;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/yuv422_to_rgb888_converter.sv]
// YUV 4:2:2 to 24-bit RGB converter.
// Input channel: in_valid/in_stall carry one macropixel per word (chroma_a,
// luma_first, chroma_b, luma_second, last_in). The word is taken at a clock
// edge where in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall carry one word holding both converted
// pixels (first_byte0..2, second_byte0..2) and last_out, a copy of last_in.
// The receiver holds off a word by raising out_stall; the word then stays put.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes channel_order:
// 0 stores each pixel as channel 0,1,2, 1 stores it reversed (BGR). cfg_ready
// is always high; write it only while no word is in flight.
// out_valid rises once an accepted word has passed the input register and then the
// output register. Throughput is one word per cycle while out_stall is low: an
// input register feeds the constant-coefficient multiplies, adds and saturation,
// which land in the output register. When the receiver stalls, the two registers
// fill and in_stall rises in the same cycle as out_stall would otherwise overflow
// them; nothing is dropped.
// Reset (arst_n low) empties both stages at once and sets channel_order to 0.
`default_nettype none
`include "assert_macros.svh"
module yuv422_to_rgb888_converter
	import yuvrgb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration write channel.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	// Input macropixel channel.
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] chroma_a,
	input  wire logic [7:0] luma_first,
	input  wire logic [7:0] chroma_b,
	input  wire logic [7:0] luma_second,
	input  wire logic       last_in,
	// Output pixel pair channel.
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      first_byte0,
	output logic [7:0]      first_byte1,
	output logic [7:0]      first_byte2,
	output logic [7:0]      second_byte0,
	output logic [7:0]      second_byte1,
	output logic [7:0]      second_byte2,
	output logic            last_out
);

	chan_order_t channel_order_q;

	// Stage 1 holds the raw macropixel, stage 2 the finished pixels.
	logic       valid_s1;
	logic [7:0] chroma_a_s1;
	logic [7:0] luma_first_s1;
	logic [7:0] chroma_b_s1;
	logic [7:0] luma_second_s1;
	logic       last_s1;

	logic       valid_s2;
	logic [7:0] first_b0_s2;
	logic [7:0] first_b1_s2;
	logic [7:0] first_b2_s2;
	logic [7:0] second_b0_s2;
	logic [7:0] second_b1_s2;
	logic [7:0] second_b2_s2;
	logic       last_s2;

	logic adv_s1;
	logic adv_s2;

	chroma_off_t chroma_off;
	logic [7:0]  first_b0;
	logic [7:0]  first_b1;
	logic [7:0]  first_b2;
	logic [7:0]  second_b0;
	logic [7:0]  second_b1;
	logic [7:0]  second_b2;

	// The register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_order_q <= ORDER_RGB;
		end else if (cfg_valid && cfg_ready) begin
			channel_order_q <= chan_order_t'(cfg_data);
		end
	end

	// A stage may load when it is empty or when its contents move on.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			chroma_a_s1    <= chroma_a;
			luma_first_s1  <= luma_first;
			chroma_b_s1    <= chroma_b;
			luma_second_s1 <= luma_second;
			last_s1        <= last_in;
		end
	end

	// The chroma terms are shared by both pixels of the macropixel.
	yuvrgb_chroma u_chroma (
		.chroma_a (chroma_a_s1),
		.chroma_b (chroma_b_s1),
		.off      (chroma_off)
	);

	yuvrgb_pixel u_pixel_first (
		.luma  (luma_first_s1),
		.off   (chroma_off),
		.order (channel_order_q),
		.byte0 (first_b0),
		.byte1 (first_b1),
		.byte2 (first_b2)
	);

	yuvrgb_pixel u_pixel_second (
		.luma  (luma_second_s1),
		.off   (chroma_off),
		.order (channel_order_q),
		.byte0 (second_b0),
		.byte1 (second_b1),
		.byte2 (second_b2)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			first_b0_s2  <= first_b0;
			first_b1_s2  <= first_b1;
			first_b2_s2  <= first_b2;
			second_b0_s2 <= second_b0;
			second_b1_s2 <= second_b1;
			second_b2_s2 <= second_b2;
			last_s2      <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign first_byte0  = first_b0_s2;
	assign first_byte1  = first_b1_s2;
	assign first_byte2  = first_b2_s2;
	assign second_byte0 = second_b0_s2;
	assign second_byte1 = second_b1_s2;
	assign second_byte2 = second_b2_s2;
	assign last_out     = last_s2;

	// An accepted word always lands in the input stage.
	`ASSERT_CLK(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall |=> valid_s1, "accepted word lost before stage 1")
	// With room at the output the converter never holds off the sender.
	`ASSERT_CLK(a_no_needless_stall, clk, arst_n, (!valid_s2 || !out_stall) |-> !in_stall, "in_stall raised with output room")
	// With both stages full and the output held, the input must be held too.
	`ASSERT_CLK(a_full_blocks_input, clk, arst_n, valid_s1 && valid_s2 && out_stall |-> in_stall, "input taken while pipeline full")
	// A configuration write is visible on the next cycle.
	`ASSERT_CLK(a_cfg_write, clk, arst_n, cfg_valid |=> channel_order_q == chan_order_t'($past(cfg_data)), "channel_order write not stored")
	// An edge seen in reset leaves the output stage empty.
	`ASSERT_CLK_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid, "output valid after reset")

endmodule
`default_nettype wire
